[src/central_gradient_magnitude_defines.svh]
// Assertion macros for the gradient magnitude RTL.
`ifndef CENTRAL_GRADIENT_MAGNITUDE_DEFINES_SVH
`define CENTRAL_GRADIENT_MAGNITUDE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define CGM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define CGM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CGM_ASSERT(lbl, prop, msg)
`define CGM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[src/cgm_pkg.sv]
// Package with sizes, register codes and shared types of the gradient magnitude block.
package cgm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 16;

  localparam int SIZE_W     = 11;
  localparam int APB_ADDR_W = 4;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CW1        = COL_W + 1;
  localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
  localparam int EMIT_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int EFFW_W     = $clog2(MAX_WIDTH + 1);
  localparam int EFFH_W     = $clog2(MAX_HEIGHT + 1);
  localparam int SQ_W       = 2 * PIXEL_BITS;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd1024;
  localparam logic              CLAMP_RESET  = 1'b1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CLAMP_EDGES  = 2'd2
  } cgm_reg_e;

  // One pixel transaction with its position flags.
  typedef struct packed {
    logic [COL_W-1:0]             col;
    logic signed [PIXEL_BITS-1:0] pix;
    logic                         emit;
    logic                         first_col;
    logic                         last_col;
    logic                         first_row;
    logic                         last_row;
    logic                         done;
    logic                         clamp;
  } cgm_item_t;

  // Gradient pair on its way to the magnitude pipeline.
  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] gx;
    logic signed [PIXEL_BITS-1:0] gy;
    logic                         done;
  } cgm_grad_t;

endpackage

[src/central_gradient_magnitude.sv]
// Top level of the streaming central-difference gradient magnitude block.
// The block takes one pixel transaction per clock while neither an output
// stall nor a remainder update holds its input, and gives one result per
// accepted item once the stream is width+1 items into the frame, so a frame
// needs width+1 padding items to flush its last row. A result passes through
// one window stage, one difference stage, one squaring stage, one sum stage
// and 16 square root stages, one root digit each. A stall on the output freezes
// the whole pipeline. A write of frame_width rebuilds the result column and
// row from the result count with a one-bit-per-clock divider; input is
// stalled while it runs. The line stores need no clearing pass after reset.
module central_gradient_magnitude (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cgm_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [cgm_pkg::PIXEL_BITS-1:0] pixel_value_i,
  input  logic                                  is_padding_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cgm_pkg::PIXEL_BITS-1:0] grad_horizontal_o,
  output logic signed [cgm_pkg::PIXEL_BITS-1:0] grad_vertical_o,
  output logic [cgm_pkg::PIXEL_BITS-1:0]        grad_magnitude_o,
  output logic                                  frame_done_o
);
  import cgm_pkg::*;

  logic      en, busy, accept, cfg_we, grad_valid;
  cgm_reg_e  cfg_idx;
  cgm_item_t item;
  cgm_grad_t grad;

  // Decode the register access.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = cgm_reg_e'(paddr[3:2]);

  // Freeze the pipeline while a result waits.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en || busy;
  assign accept     = in_valid_i && !in_stall_o;

  cgm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (pwdata),
    .cfg_rdata_o   (prdata),
    .in_accept_i   (accept),
    .pixel_value_i (pixel_value_i),
    .is_padding_i  (is_padding_i),
    .busy_o        (busy),
    .item_o        (item)
  );

  cgm_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (accept),
    .item_i  (item),
    .valid_o (grad_valid),
    .grad_o  (grad)
  );

  cgm_magnitude u_magnitude (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (grad_valid),
    .grad_i            (grad),
    .valid_o           (out_valid_o),
    .grad_horizontal_o (grad_horizontal_o),
    .grad_vertical_o   (grad_vertical_o),
    .grad_magnitude_o  (grad_magnitude_o),
    .frame_done_o      (frame_done_o)
  );

endmodule

[src/cgm_ram.sv]
// Generic simple dual-port RAM with registered read.
module cgm_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and read; a read at the written address returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[src/cgm_ctrl.sv]
// Configuration registers, frame position counters and remainder update.
`include "central_gradient_magnitude_defines.svh"
module cgm_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  cgm_pkg::cgm_reg_e               cfg_idx_i,
  input  logic [31:0]                     cfg_wdata_i,
  output logic [31:0]                     cfg_rdata_o,
  input  logic                            in_accept_i,
  input  logic signed [cgm_pkg::PIXEL_BITS-1:0] pixel_value_i,
  input  logic                            is_padding_i,
  output logic                            busy_o,
  output cgm_pkg::cgm_item_t              item_o
);
  import cgm_pkg::*;

  localparam int DIV_CNT_W = $clog2(EMIT_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(EMIT_W - 1);
  localparam int RW1 = EMIT_W + 1;

  function automatic logic [EFFW_W-1:0] eff_width(input logic [SIZE_W-1:0] raw);
    int unsigned r;
    r = int'(raw);
    if (r == 0) r = 1;
    else if (r > MAX_WIDTH) r = MAX_WIDTH;
    return EFFW_W'(r);
  endfunction

  function automatic logic [EFFH_W-1:0] eff_height(input logic [SIZE_W-1:0] raw);
    int unsigned r;
    r = int'(raw);
    if (r == 0) r = 1;
    else if (r > MAX_HEIGHT) r = MAX_HEIGHT;
    return EFFH_W'(r);
  endfunction

  logic [SIZE_W-1:0]    width_q, height_q;
  logic                 clamp_q;
  logic [COL_W-1:0]     col_q, cc_q;
  logic [ROW_W-1:0]     row_q;
  logic [EMIT_W-1:0]    emitted_q, cr_q;
  logic                 busy_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [EFFW_W-1:0]    div_rem_q, div_rem_d;
  logic [EMIT_W-1:0]    div_quot_q, div_quot_d;

  logic [EFFW_W-1:0] w_eff;
  logic [EFFH_W-1:0] h_eff;
  logic [CW1-1:0]    col1, cc1;
  logic [RW1-1:0]    cr1;
  logic              row_wrap, last_col, last_row, emit, done;
  logic [EFFW_W:0]   rem_sh, rem_sub;
  logic              div_ge;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      clamp_q  <= CLAMP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[SIZE_W-1:0];
        REG_FRAME_HEIGHT: height_q <= cfg_wdata_i[SIZE_W-1:0];
        REG_CLAMP_EDGES:  clamp_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Return register values.
  always_comb begin
    unique case (cfg_idx_i)
      REG_FRAME_WIDTH:  cfg_rdata_o = 32'(width_q);
      REG_FRAME_HEIGHT: cfg_rdata_o = 32'(height_q);
      REG_CLAMP_EDGES:  cfg_rdata_o = 32'(clamp_q);
      default:          cfg_rdata_o = '0;
    endcase
  end

  // Derive position flags of the incoming transaction.
  always_comb begin
    w_eff    = eff_width(width_q);
    h_eff    = eff_height(height_q);
    col1     = CW1'(col_q) + CW1'(1);
    row_wrap = col1 >= CW1'(w_eff);
    cc1      = CW1'(cc_q) + CW1'(1);
    last_col = cc1 >= CW1'(w_eff);
    cr1      = RW1'(cr_q) + RW1'(1);
    last_row = cr1 >= RW1'(h_eff);
    emit     = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0)) ||
               ((row_q == '0) && (CW1'(col_q) > CW1'(w_eff)));
    done     = (cr1 > RW1'(h_eff)) || ((cr1 == RW1'(h_eff)) && last_col);

    item_o.col       = col_q;
    item_o.pix       = is_padding_i ? '0 : pixel_value_i;
    item_o.emit      = emit;
    item_o.first_col = (cc_q == '0);
    item_o.last_col  = last_col;
    item_o.first_row = (cr_q == '0);
    item_o.last_row  = last_row;
    item_o.done      = done;
    item_o.clamp     = clamp_q;
  end

  // Run one restoring division step of the result count by the width.
  always_comb begin
    rem_sh     = {div_rem_q, div_quot_q[EMIT_W-1]};
    div_ge     = rem_sh >= (EFFW_W+1)'(w_eff);
    rem_sub    = rem_sh - (EFFW_W+1)'(w_eff);
    div_rem_d  = div_ge ? rem_sub[EFFW_W-1:0] : rem_sh[EFFW_W-1:0];
    div_quot_d = {div_quot_q[EMIT_W-2:0], div_ge};
  end

  // Advance counters per transaction; rebuild column and row after a width write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      emitted_q  <= '0;
      cc_q       <= '0;
      cr_q       <= '0;
      busy_q     <= 1'b0;
      div_cnt_q  <= '0;
      div_rem_q  <= '0;
      div_quot_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == REG_FRAME_WIDTH)) begin
      busy_q     <= 1'b1;
      div_cnt_q  <= '0;
      div_rem_q  <= '0;
      div_quot_q <= emitted_q;
    end else if (busy_q) begin
      div_cnt_q  <= div_cnt_q + DIV_CNT_W'(1);
      div_rem_q  <= div_rem_d;
      div_quot_q <= div_quot_d;
      if (div_cnt_q == DIV_LAST) begin
        busy_q <= 1'b0;
        cc_q   <= div_rem_d[COL_W-1:0];
        cr_q   <= div_quot_d;
      end
    end else if (in_accept_i) begin
      if (row_wrap) begin
        col_q <= '0;
        row_q <= row_q + ROW_W'(1);
      end else begin
        col_q <= col1[COL_W-1:0];
      end
      if (emit) begin
        if (done) begin
          emitted_q <= '0;
          cc_q      <= '0;
          cr_q      <= '0;
          col_q     <= '0;
          row_q     <= '0;
        end else begin
          emitted_q <= emitted_q + EMIT_W'(1);
          if (last_col) begin
            cc_q <= '0;
            cr_q <= cr_q + EMIT_W'(1);
          end else begin
            cc_q <= cc1[COL_W-1:0];
          end
        end
      end
    end
  end

  assign busy_o = busy_q;

  `CGM_ASSERT_NEVER(a_no_accept_busy, busy_q && in_accept_i, "transaction during remainder update")
  `CGM_ASSERT(a_div_ends, busy_q && (div_cnt_q == DIV_LAST) |=> !busy_q, "divider overran")
  `CGM_ASSERT(a_cc_in_row, !busy_q |-> (CW1'(cc_q) < CW1'(w_eff)), "result column past width")
  `CGM_ASSERT(a_done_clr, in_accept_i && emit && done |=> ~|{emitted_q, col_q}, "counts kept")

endmodule

[src/cgm_window.sv]
// Line stores, 3x3 window and central differences.
module cgm_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cgm_pkg::cgm_item_t item_i,
  output logic               valid_o,
  output cgm_pkg::cgm_grad_t grad_o
);
  import cgm_pkg::*;

  logic            s1_valid_q;
  cgm_item_t       s1_q;
  logic [PIXEL_BITS-1:0] up_rd, mid_rd;
  logic            fwd_q;
  logic signed [PIXEL_BITS-1:0] fwd_up_q, fwd_mid_q;
  logic signed [PIXEL_BITS-1:0] up_eff, mid_eff;
  logic signed [PIXEL_BITS-1:0] w2_q, w4_q, w5_q, w8_q;
  logic signed [PIXEL_BITS-1:0] outside, left, right, above, below;
  logic signed [PIXEL_BITS:0]   dx, dy;
  logic            wr_en;
  logic            s2_valid_q;
  cgm_grad_t       s2_q;

  assign wr_en = en_i && s1_valid_q;

  cgm_ram #(.Width(PIXEL_BITS), .Depth(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_q.col),
    .wdata_i (mid_eff),
    .re_i    (en_i),
    .raddr_i (item_i.col),
    .rdata_o (up_rd)
  );

  cgm_ram #(.Width(PIXEL_BITS), .Depth(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_q.col),
    .wdata_i (s1_q.pix),
    .re_i    (en_i),
    .raddr_i (item_i.col),
    .rdata_o (mid_rd)
  );

  // Forward the column written in the same cycle as it was read.
  assign mid_eff = fwd_q ? fwd_mid_q : $signed(mid_rd);
  assign up_eff  = fwd_q ? fwd_up_q  : $signed(up_rd);

  // Substitute edge neighbors and take halved differences.
  always_comb begin
    outside = s1_q.clamp ? w5_q : '0;
    left    = s1_q.first_col ? outside : w4_q;
    right   = s1_q.last_col  ? outside : mid_eff;
    above   = s1_q.first_row ? outside : w2_q;
    below   = s1_q.last_row  ? outside : w8_q;
    dx      = (PIXEL_BITS+1)'(right) - (PIXEL_BITS+1)'(left);
    dy      = (PIXEL_BITS+1)'(below) - (PIXEL_BITS+1)'(above);
  end

  // Advance control of stages one and two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q && s1_q.emit;
      fwd_q      <= s1_valid_q && (s1_q.col == item_i.col);
    end
  end

  // Shift the window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w2_q <= '0;
      w4_q <= '0;
      w5_q <= '0;
      w8_q <= '0;
    end else if (wr_en) begin
      w2_q <= up_eff;
      w4_q <= w5_q;
      w5_q <= mid_eff;
      w8_q <= s1_q.pix;
    end
  end

  // Hold payload of stages one and two.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q      <= item_i;
      fwd_up_q  <= mid_eff;
      fwd_mid_q <= s1_q.pix;
      s2_q.gx   <= dx[PIXEL_BITS:1];
      s2_q.gy   <= dy[PIXEL_BITS:1];
      s2_q.done <= s1_q.done;
    end
  end

  assign valid_o = s2_valid_q;
  assign grad_o  = s2_q;

endmodule

[src/cgm_magnitude.sv]
// Squares, sum and pipelined integer square root with the output register.
module cgm_magnitude (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  cgm_pkg::cgm_grad_t                     grad_i,
  output logic                                   valid_o,
  output logic signed [cgm_pkg::PIXEL_BITS-1:0]  grad_horizontal_o,
  output logic signed [cgm_pkg::PIXEL_BITS-1:0]  grad_vertical_o,
  output logic [cgm_pkg::PIXEL_BITS-1:0]         grad_magnitude_o,
  output logic                                   frame_done_o
);
  import cgm_pkg::*;

  localparam int STEPS = PIXEL_BITS;

  function automatic logic [SQ_W-1:0] sqrt_bit(input int unsigned step);
    return SQ_W'(1) << (SQ_W - 2 - 2 * step);
  endfunction

  logic signed [PIXEL_BITS:0] gxe, gye;
  logic [PIXEL_BITS:0]        ax, ay;
  logic [2*PIXEL_BITS+1:0]    sqx, sqy;

  logic            sq_valid_q;
  cgm_grad_t       sq_grad_q;
  logic [SQ_W-1:0] sqx_q, sqy_q;

  logic            v_q    [STEPS+1];
  cgm_grad_t       g_q    [STEPS+1];
  logic [SQ_W-1:0] n_q    [STEPS+1];
  logic [SQ_W-1:0] r_q    [STEPS+1];
  logic [SQ_W-1:0] n_d    [STEPS];
  logic [SQ_W-1:0] r_d    [STEPS];
  logic [SQ_W-1:0] trial  [STEPS];

  // Take absolute values and square them.
  always_comb begin
    gxe = {grad_i.gx[PIXEL_BITS-1], grad_i.gx};
    gye = {grad_i.gy[PIXEL_BITS-1], grad_i.gy};
    ax  = gxe[PIXEL_BITS] ? $unsigned(-gxe) : $unsigned(gxe);
    ay  = gye[PIXEL_BITS] ? $unsigned(-gye) : $unsigned(gye);
    sqx = ax * ax;
    sqy = ay * ay;
  end

  // Run one root digit per stage.
  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      trial[i] = r_q[i] + sqrt_bit(i);
      if (n_q[i] >= trial[i]) begin
        n_d[i] = n_q[i] - trial[i];
        r_d[i] = (r_q[i] >> 1) + sqrt_bit(i);
      end else begin
        n_d[i] = n_q[i];
        r_d[i] = r_q[i] >> 1;
      end
    end
  end

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      for (int i = 0; i <= STEPS; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      sq_valid_q <= valid_i;
      v_q[0]     <= sq_valid_q;
      for (int i = 0; i < STEPS; i++) v_q[i+1] <= v_q[i];
    end
  end

  // Advance payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_grad_q <= grad_i;
      sqx_q     <= sqx[SQ_W-1:0];
      sqy_q     <= sqy[SQ_W-1:0];
      g_q[0]    <= sq_grad_q;
      n_q[0]    <= sqx_q + sqy_q;
      r_q[0]    <= '0;
      for (int i = 0; i < STEPS; i++) begin
        g_q[i+1] <= g_q[i];
        n_q[i+1] <= n_d[i];
        r_q[i+1] <= r_d[i];
      end
    end
  end

  assign valid_o           = v_q[STEPS];
  assign grad_horizontal_o = g_q[STEPS].gx;
  assign grad_vertical_o   = g_q[STEPS].gy;
  assign grad_magnitude_o  = r_q[STEPS][PIXEL_BITS-1:0];
  assign frame_done_o      = g_q[STEPS].done;

endmodule

[test/cgm_checker.sv]
// Checker: predicts gradient results from observed transactions and compares them.
`timescale 1ns / 100ps

module cgm_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cgm_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [31:0]                           pwdata,
  input  logic                                  pready,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic signed [cgm_pkg::PIXEL_BITS-1:0] pixel_value_i,
  input  logic                                  is_padding_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [cgm_pkg::PIXEL_BITS-1:0] grad_horizontal_i,
  input  logic signed [cgm_pkg::PIXEL_BITS-1:0] grad_vertical_i,
  input  logic [cgm_pkg::PIXEL_BITS-1:0]        grad_magnitude_i,
  input  logic                                  frame_done_i,
  output int                                    errors_o,
  output int                                    pending_o
);
  import cgm_pkg::*;

  typedef struct {
    logic signed [PIXEL_BITS-1:0] gx;
    logic signed [PIXEL_BITS-1:0] gy;
    logic [PIXEL_BITS-1:0]        mag;
    logic                         done;
  } grad_result_t;

  grad_result_t grad_queue[$];

  // Shadow registers and stencil state
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  logic              clamp_q;
  longint            upper_row[MAX_WIDTH];
  longint            middle_row[MAX_WIDTH];
  longint            win[9];
  int unsigned       col_cnt;
  int unsigned       row_cnt;
  int unsigned       emit_cnt;

  function automatic int unsigned eff_size(logic [SIZE_W-1:0] raw, int unsigned maxv);
    if (raw == 0) return 1;
    return (raw > maxv) ? maxv : raw;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Advance the window by one transaction and queue a result when one is due
  task automatic predict_gradient(logic signed [PIXEL_BITS-1:0] pix, logic pad);
    int unsigned  w;
    int unsigned  h;
    int unsigned  k;
    int unsigned  cc;
    int unsigned  cr;
    longint       v;
    longint       t;
    longint       outside;
    longint       lft, rgt, abv, blw, gx, gy;
    grad_result_t res;
    w = eff_size(width_q, MAX_WIDTH);
    h = eff_size(height_q, MAX_HEIGHT);
    v = pad ? 0 : longint'(pix);
    k = col_cnt % MAX_WIDTH;
    t = longint'(row_cnt) * w + col_cnt;
    for (int r = 0; r < 3; r++) begin
      win[r*3+0] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = upper_row[k];
    win[5] = middle_row[k];
    win[8] = v;
    upper_row[k] = middle_row[k];
    middle_row[k] = v;
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) & 32'h7FF;
    end
    if (t < w + 1) return;
    cc = emit_cnt % w;
    cr = emit_cnt / w;
    outside = clamp_q ? win[4] : 0;
    lft = (cc == 0) ? outside : win[3];
    rgt = (cc + 1 >= w) ? outside : win[5];
    abv = (cr == 0) ? outside : win[1];
    blw = (cr + 1 >= h) ? outside : win[7];
    gx = (rgt - lft) >>> 1;
    gy = (blw - abv) >>> 1;
    res.gx = gx[PIXEL_BITS-1:0];
    res.gy = gy[PIXEL_BITS-1:0];
    res.mag = PIXEL_BITS'(int_sqrt(longint'(gx * gx + gy * gy)));
    res.done = (longint'(emit_cnt) + 1 >= longint'(w) * h);
    grad_queue.push_back(res);
    if (res.done) begin
      emit_cnt = 0;
      col_cnt = 0;
      row_cnt = 0;
    end else begin
      emit_cnt = (emit_cnt + 1) & 32'hFFFFF;
    end
  endtask

  // Track register writes, predict on input transactions, compare outputs
  always @(posedge clk_i or negedge rst_ni) begin
    grad_result_t head;
    if (!rst_ni) begin
      width_q  = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      clamp_q  = CLAMP_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i]  = 0;
        middle_row[i] = 0;
      end
      for (int i = 0; i < 9; i++) win[i] = 0;
      col_cnt  = 0;
      row_cnt  = 0;
      emit_cnt = 0;
      grad_queue.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cgm_reg_e'(paddr[3:2]))
          REG_FRAME_WIDTH:  width_q  = pwdata[SIZE_W-1:0];
          REG_FRAME_HEIGHT: height_q = pwdata[SIZE_W-1:0];
          REG_CLAMP_EDGES:  clamp_q  = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_gradient(pixel_value_i, is_padding_i);
      if (out_valid_i && !out_stall_i) begin
        if (grad_queue.size() == 0) begin
          $error("unexpected result transaction: gx %0d gy %0d mag %0d done %0d",
                 grad_horizontal_i, grad_vertical_i, grad_magnitude_i, frame_done_i);
          errors_o++;
        end else begin
          head = grad_queue.pop_front();
          if (grad_horizontal_i !== head.gx) begin
            $error("grad_horizontal: expected %0d, actual %0d", head.gx, grad_horizontal_i);
            errors_o++;
          end
          if (grad_vertical_i !== head.gy) begin
            $error("grad_vertical: expected %0d, actual %0d", head.gy, grad_vertical_i);
            errors_o++;
          end
          if (grad_magnitude_i !== head.mag) begin
            $error("grad_magnitude: expected %0d, actual %0d", head.mag, grad_magnitude_i);
            errors_o++;
          end
          if (frame_done_i !== head.done) begin
            $error("frame_done: expected %0d, actual %0d", head.done, frame_done_i);
            errors_o++;
          end
        end
      end
      pending_o = grad_queue.size();
    end
  end

endmodule

[test/testbench.sv]
// Testbench top: drives frames and register writes into the gradient block.
`timescale 1ns / 100ps

module testbench;
  import cgm_pkg::*;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0]        paddr;
  logic [31:0]                  pwdata, prdata;
  logic                         in_valid_i, in_stall_o;
  logic signed [PIXEL_BITS-1:0] pixel_value_i;
  logic                         is_padding_i;
  logic                         out_valid_o, out_stall_i;
  logic signed [PIXEL_BITS-1:0] grad_horizontal_o, grad_vertical_o;
  logic [PIXEL_BITS-1:0]        grad_magnitude_o;
  logic                         frame_done_o;
  int                           errors, pending;
  int                           items_sent;
  int                           frames_sent;

  central_gradient_magnitude u_top (.*);

  cgm_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_i(in_stall_o), .pixel_value_i, .is_padding_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .grad_horizontal_i(grad_horizontal_o), .grad_vertical_i(grad_vertical_o),
    .grad_magnitude_i(grad_magnitude_o), .frame_done_i(frame_done_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hold a generous ceiling on the run
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // Pick a gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive the output stall with random stretches of free flow
  initial begin
    int quiet;
    out_stall_i = 1'b0;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (quiet > 0) begin
        quiet--;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        quiet = $urandom_range(50, 300);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= (pick_gap() > 0);
      end
    end
  end

  task automatic apb_write(cgm_reg_e idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << 2;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Send one transaction and hold it until accepted
  task automatic send_item(logic signed [PIXEL_BITS-1:0] pix, logic pad, bit no_gaps);
    int gap;
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    is_padding_i  <= pad;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [PIXEL_BITS-1:0] pick_pixel(int kind, int idx);
    int r;
    if (kind == 1) return (idx % 2) ? 16'sh7FFF : 16'sh8000;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7FFF;
    if (r == 2) return PIXEL_BITS'(int'($urandom_range(0, 15)) - 8);
    return PIXEL_BITS'($urandom);
  endfunction

  // Wait out the pipeline, then program all three registers
  task automatic configure(logic [10:0] w, logic [10:0] h, logic clamp);
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    apb_write(REG_FRAME_WIDTH, 32'(w));
    apb_write(REG_FRAME_HEIGHT, 32'(h));
    apb_write(REG_CLAMP_EDGES, 32'(clamp));
  endtask

  // Send one frame plus its flush; kind 1 alternates extremes
  task automatic run_frame(logic [10:0] w_raw, logic [10:0] h_raw, int kind,
                           bit noisy, bit no_gaps);
    int w;
    int h;
    w = (w_raw == 0) ? 1 : ((w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw);
    h = (h_raw == 0) ? 1 : ((h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw);
    for (int i = 0; i < w * h; i++)
      send_item(pick_pixel(kind, i), noisy && ($urandom_range(0, 15) == 0), no_gaps);
    for (int i = 0; i <= w; i++)
      send_item(PIXEL_BITS'($urandom), !(noisy && ($urandom_range(0, 7) == 0)), no_gaps);
    frames_sent++;
  endtask

  initial begin
    logic     clamp;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    pixel_value_i = '0;
    is_padding_i  = 1'b0;
    items_sent    = 0;
    frames_sent   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames: extremes, both edge modes, sizes of zero
    configure(11'd3, 11'd3, 1'b1);
    run_frame(11'd3, 11'd3, 1, 1'b0, 1'b1);
    configure(11'd3, 11'd3, 1'b0);
    run_frame(11'd3, 11'd3, 1, 1'b1, 1'b0);
    configure(11'd0, 11'd0, 1'b0);
    run_frame(11'd0, 11'd0, 0, 1'b0, 1'b0);

    // Random small frames, sometimes back to back without reprogramming
    while (items_sent < 1200) begin
      logic [10:0] w;
      logic [10:0] h;
      w = 11'($urandom_range(0, 10));
      h = 11'($urandom_range(0, 8));
      clamp = 1'($urandom_range(0, 1));
      configure(w, h, clamp);
      repeat ($urandom_range(1, 3)) run_frame(w, h, 0, $urandom_range(0, 3) == 0, 1'b0);
    end

    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d transactions in %0d frames up to 10 by 8, zero sizes included,",
             items_sent, frames_sent);
    $display("both edge modes, padding mid-frame and pixels during the flush.");
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/cgm_pkg.sv
src/cgm_ram.sv
src/cgm_ctrl.sv
src/cgm_window.sv
src/cgm_magnitude.sv
src/central_gradient_magnitude.sv
test/cgm_checker.sv
test/testbench.sv
